/* hdl/mss_pkg.sv */
// ----------------------------------------------------------------------------
// mss_pkg
// Shared widths, codes and types for the mux sensor scan smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int SAMPLE_W = 12;
  localparam int RSLOT_W  = 4;
  localparam int SEL_W    = 3;
  localparam int SHIFT_W  = 4;
  localparam int SETTLE_W = 8;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_SHIFT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_TICKS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE_ORDER = 2'd2;

  localparam logic [SHIFT_W-1:0]  FILTER_SHIFT_RST = 4'd2;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 8'd2;
  localparam logic [SETTLE_W-1:0] SETTLE_MAX       = 8'hFF;

  typedef struct packed {
    logic [SEL_W-1:0]    mux_select;
    logic                sample_stored;
    logic [SEL_W-1:0]    slot_written;
    logic [SAMPLE_W-1:0] raw_value;
    logic [SAMPLE_W-1:0] smooth_value;
    logic                scan_valid;
  } result_t;

endpackage

`default_nettype wire

/* hdl/mss_in_if.sv */
// ----------------------------------------------------------------------------
// mss_in_if
// Input channel: valid/ready handshake with command, sample and read slot.
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_in_if;
  logic                          valid;
  logic                          ready;
  logic [mss_pkg::FUNC_W-1:0]    func;
  logic [mss_pkg::SAMPLE_W-1:0]  adc_sample;
  logic [mss_pkg::RSLOT_W-1:0]   read_slot;

  modport source (output valid, output func, output adc_sample, output read_slot,
                  input ready);
  modport sink   (input valid, input func, input adc_sample, input read_slot,
                  output ready);
endinterface

`default_nettype wire

/* hdl/mss_out_if.sv */
// ----------------------------------------------------------------------------
// mss_out_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_out_if;
  logic                          valid;
  logic                          ready;
  logic [mss_pkg::SEL_W-1:0]     mux_select;
  logic                          sample_stored;
  logic [mss_pkg::SEL_W-1:0]     slot_written;
  logic [mss_pkg::SAMPLE_W-1:0]  raw_value;
  logic [mss_pkg::SAMPLE_W-1:0]  smooth_value;
  logic                          scan_valid;

  modport source (output valid, output mux_select, output sample_stored,
                  output slot_written, output raw_value, output smooth_value,
                  output scan_valid, input ready);
  modport sink   (input valid, input mux_select, input sample_stored,
                  input slot_written, input raw_value, input smooth_value,
                  input scan_valid, output ready);
endinterface

`default_nettype wire

/* hdl/mux_sensor_scan_smoother.sv */
// ----------------------------------------------------------------------------
// mux_sensor_scan_smoother
// Analog mux scanner with per-channel raw store and exponential smoothing.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid entry when
// out is stalled. One transaction per cycle while the skid is empty; at most
// one slot update per transaction. A two-entry output buffer (result register
// plus skid) keeps in ready independent of out ready.
// Reset (rst_n low, synchronous): stores, scan state and registers return to
// their defaults; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module mux_sensor_scan_smoother #(
  parameter int CHANNELS = mss_pkg::CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data,
  mss_in_if.sink                               in_ch,
  mss_out_if.source                            out_ch
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  // configuration
  logic [mss_pkg::SHIFT_W-1:0]  filter_shift_r;
  logic [mss_pkg::SETTLE_W-1:0] settle_ticks_r;
  logic                         reverse_order_r;

  // scan state
  logic [mss_pkg::SAMPLE_W-1:0] raw_r    [CHANNELS];
  logic [mss_pkg::SAMPLE_W-1:0] smooth_r [CHANNELS];
  logic [IDX_W-1:0]             pos_r;
  logic                         waiting_r;
  logic [mss_pkg::SETTLE_W-1:0] settle_r;
  logic                         pass_done_r;
  logic [mss_pkg::SEL_W-1:0]    sel_r;

  // output buffer
  logic                         out_v_r;
  logic                         skid_v_r;
  mss_pkg::result_t             out_r;
  mss_pkg::result_t             skid_r;

  logic                         in_ready;
  logic                         acc;
  logic                         is_tick;
  logic                         is_poll;
  logic                         is_read;
  logic                         poll_sel;
  logic                         poll_store;
  logic                         rd_ok;
  logic [IDX_W-1:0]             slot;
  logic [IDX_W-1:0]             rd_addr;
  logic [mss_pkg::SAMPLE_W-1:0] old_raw;
  logic [mss_pkg::SAMPLE_W-1:0] old_smooth;
  logic signed [mss_pkg::SAMPLE_W:0] diff;
  logic signed [mss_pkg::SAMPLE_W:0] step;
  logic [mss_pkg::SAMPLE_W:0]   filt_sum;
  logic [mss_pkg::SAMPLE_W-1:0] smooth_new;
  logic                         pos_last;
  mss_pkg::result_t             res;

  assign in_ready    = rst_n && !skid_v_r;
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  assign is_tick = (in_ch.func == mss_pkg::FUNC_TICK);
  assign is_poll = (in_ch.func == mss_pkg::FUNC_POLL);
  assign is_read = (in_ch.func == mss_pkg::FUNC_READ);

  assign poll_sel   = is_poll && !waiting_r;
  assign poll_store = is_poll && waiting_r && (settle_r >= settle_ticks_r);
  assign rd_ok      = in_ch.read_slot < mss_pkg::RSLOT_W'(CHANNELS);
  assign pos_last   = (pos_r == LAST_IDX);

  assign slot    = reverse_order_r ? (LAST_IDX - pos_r) : pos_r;
  assign rd_addr = is_read ? in_ch.read_slot[IDX_W-1:0] : slot;

  assign old_raw    = raw_r[rd_addr];
  assign old_smooth = smooth_r[rd_addr];

  // old + ((new - old) >>> shift), floor semantics
  assign diff       = $signed({1'b0, in_ch.adc_sample}) - $signed({1'b0, old_smooth});
  assign step       = diff >>> filter_shift_r;
  assign filt_sum   = {1'b0, old_smooth} + step;
  assign smooth_new = pass_done_r ? filt_sum[mss_pkg::SAMPLE_W-1:0] : in_ch.adc_sample;

  always_comb begin
    res               = '0;
    res.mux_select    = poll_sel ? mss_pkg::SEL_W'(pos_r) : sel_r;
    res.sample_stored = poll_store;
    res.scan_valid    = pass_done_r || (poll_store && pos_last);
    if (poll_store) begin
      res.slot_written = mss_pkg::SEL_W'(slot);
      res.raw_value    = in_ch.adc_sample;
      res.smooth_value = smooth_new;
    end else if (is_read && rd_ok) begin
      res.raw_value    = old_raw;
      res.smooth_value = old_smooth;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_shift_r  <= mss_pkg::FILTER_SHIFT_RST;
      settle_ticks_r  <= mss_pkg::SETTLE_TICKS_RST;
      reverse_order_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mss_pkg::CFG_FILTER_SHIFT:  filter_shift_r  <= cfg_data[mss_pkg::SHIFT_W-1:0];
        mss_pkg::CFG_SETTLE_TICKS:  settle_ticks_r  <= cfg_data[mss_pkg::SETTLE_W-1:0];
        mss_pkg::CFG_REVERSE_ORDER: reverse_order_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        raw_r[i]    <= '0;
        smooth_r[i] <= '0;
      end
      pos_r       <= '0;
      waiting_r   <= 1'b0;
      settle_r    <= '0;
      pass_done_r <= 1'b0;
      sel_r       <= '0;
    end else if (acc) begin
      if (is_tick) begin
        if (settle_r != mss_pkg::SETTLE_MAX) begin
          settle_r <= settle_r + 1'b1;
        end
      end else if (poll_sel) begin
        sel_r     <= mss_pkg::SEL_W'(pos_r);
        settle_r  <= '0;
        waiting_r <= 1'b1;
      end else if (poll_store) begin
        raw_r[slot]    <= in_ch.adc_sample;
        smooth_r[slot] <= smooth_new;
        waiting_r      <= 1'b0;
        if (pos_last) begin
          pos_r       <= '0;
          pass_done_r <= 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_ch.ready) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (acc) begin
        if (!out_v_r || out_ch.ready) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ch.ready) begin
        out_r <= skid_r;
      end
    end else if (acc) begin
      if (!out_v_r || out_ch.ready) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.mux_select    = out_r.mux_select;
  assign out_ch.sample_stored = out_r.sample_stored;
  assign out_ch.slot_written  = out_r.slot_written;
  assign out_ch.raw_value     = out_r.raw_value;
  assign out_ch.smooth_value  = out_r.smooth_value;
  assign out_ch.scan_valid    = out_r.scan_valid;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a result in the output register");

  a_store_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && poll_store) |=> !waiting_r)
    else $error("stored sample did not return scan to select phase");

  a_pass_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    pass_done_r |=> pass_done_r)
    else $error("scan valid flag cleared outside reset");

  a_settle_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_tick && (settle_r == mss_pkg::SETTLE_MAX)) |=>
      (settle_r == mss_pkg::SETTLE_MAX))
    else $error("settle counter wrapped");

endmodule

`default_nettype wire

/* verif/tb_mux_sensor_scan_smoother.sv */
// ----------------------------------------------------------------------------
// tb_mux_sensor_scan_smoother
// Self-checking bench for the mux sensor scan smoother. A short directed
// table covers reset state, bad read slots, the unused function code and the
// first stored sample. Random scan sequences (select poll, settle ticks,
// sampling poll, reads, noise) then run under several register settings and
// idle patterns. Each untyped input transaction is predicted by a scan and
// filter model in the bench; results are checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mux_sensor_scan_smoother;
  import mss_pkg::*;

  localparam int CH          = CHANNELS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_CAP   = 100;
  localparam int N_DIR       = 20;
  localparam int N_PHASES    = 7;
  localparam int HOLD_CYCLES = 300;
  localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   fn;
    logic [SAMPLE_W-1:0] smp;
    logic [RSLOT_W-1:0]  rs;
    logic                typed;
    result_t             res;
  } stim_row_t;

  typedef struct packed {
    logic [SHIFT_W-1:0]  shift;
    logic [SETTLE_W-1:0] settle;
    logic                rev;
    int                  idle_pct;
    int                  stall_pct;
    int                  items;
    logic                press;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mss_in_if  in_bus ();
  mss_out_if out_bus ();

  mux_sensor_scan_smoother #(.CHANNELS(CH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .in_ch   (in_bus),
    .out_ch  (out_bus)
  );

  always #4 clk = ~clk;

  // Directed table; typed rows carry their own expectation.
  stim_row_t dir_rows [N_DIR] = '{
    '{FUNC_READ, 12'h000, 4'd0,  1'b1, '0},
    '{FUNC_READ, 12'hFFF, 4'd15, 1'b1, '0},
    '{FUNC_READ, 12'h000, 4'd8,  1'b1, '0},
    '{FUNC_TICK, 12'hFFF, 4'd15, 1'b1, '0},
    '{FUNC_IDLE, 12'hFFF, 4'd15, 1'b1, '0},
    '{FUNC_POLL, 12'hFFF, 4'd0,  1'b1, '0},
    '{FUNC_POLL, 12'hFFF, 4'd0,  1'b1, '0},
    '{FUNC_TICK, 12'h000, 4'd0,  1'b1, '0},
    '{FUNC_POLL, 12'hABC, 4'd0,  1'b1, '0},
    '{FUNC_TICK, 12'h000, 4'd0,  1'b1, '0},
    '{FUNC_POLL, 12'hFFF, 4'd0,  1'b1, '{3'd0, 1'b1, 3'd0, 12'hFFF, 12'hFFF, 1'b0}},
    '{FUNC_READ, 12'h000, 4'd0,  1'b1, '{3'd0, 1'b0, 3'd0, 12'hFFF, 12'hFFF, 1'b0}},
    '{FUNC_POLL, 12'h000, 4'd0,  1'b1, '{3'd1, 1'b0, 3'd0, 12'h000, 12'h000, 1'b0}},
    '{FUNC_TICK, 12'h123, 4'd3,  1'b0, '0},
    '{FUNC_TICK, 12'h456, 4'd5,  1'b0, '0},
    '{FUNC_POLL, 12'h000, 4'd0,  1'b0, '0},
    '{FUNC_READ, 12'h000, 4'd1,  1'b0, '0},
    '{FUNC_READ, 12'h000, 4'd7,  1'b0, '0},
    '{FUNC_POLL, 12'h555, 4'd10, 1'b0, '0},
    '{FUNC_POLL, 12'hAAA, 4'd12, 1'b0, '0}
  };

  phase_t phases [N_PHASES] = '{
    '{4'd0,  8'd0,   1'b0, 0,  0,  130, 1'b0},
    '{4'd15, 8'd1,   1'b1, 52, 0,  130, 1'b0},
    '{4'd3,  8'd3,   1'b0, 0,  52, 130, 1'b0},
    '{4'd1,  8'd2,   1'b1, 14, 14, 130, 1'b0},
    '{4'd7,  8'd0,   1'b0, 0,  0,  130, 1'b1},
    '{4'd2,  8'd255, 1'b1, 0,  0,  1,   1'b0},
    '{4'd15, 8'd1,   1'b0, 14, 14, 130, 1'b0}
  };

  // Scan and filter model state
  logic [SAMPLE_W-1:0] raw_mem    [CH];
  logic [SAMPLE_W-1:0] smooth_mem [CH];
  logic [SEL_W-1:0]    scan_pos;
  logic [SEL_W-1:0]    sel_lines;
  logic                waiting;
  logic                pass_done;
  logic [SETTLE_W-1:0] settle_cnt;
  logic [SHIFT_W-1:0]  cur_shift;
  logic [SETTLE_W-1:0] cur_settle;
  logic                cur_rev;

  result_t expected_q [$];
  int      mismatches = 0;
  int      idle_run = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_req = 0;
  logic    drv_typed = 1'b0;
  result_t drv_res = '0;

  function automatic void scan_reset();
    for (int k = 0; k < CH; k++) begin
      raw_mem[k]    = '0;
      smooth_mem[k] = '0;
    end
    scan_pos   = '0;
    sel_lines  = '0;
    waiting    = 1'b0;
    pass_done  = 1'b0;
    settle_cnt = '0;
    cur_shift  = FILTER_SHIFT_RST;
    cur_settle = SETTLE_TICKS_RST;
    cur_rev    = 1'b0;
  endfunction

  // old + floor((new - old) / 2^shift)
  function automatic logic [SAMPLE_W-1:0] ema_step(input logic [SAMPLE_W-1:0] old_v,
                                                   input logic [SAMPLE_W-1:0] new_v,
                                                   input logic [SHIFT_W-1:0]  sh);
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W+1:0] acc;
    diff = $signed({1'b0, new_v}) - $signed({1'b0, old_v});
    acc  = $signed({2'b00, old_v}) + (diff >>> sh);
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic result_t scan_model(input logic [FUNC_W-1:0]   fn,
                                         input logic [SAMPLE_W-1:0] smp,
                                         input logic [RSLOT_W-1:0]  rs);
    result_t r;
    int      pos;
    int      slot;
    r = '0;
    case (fn)
      FUNC_TICK: begin
        if (settle_cnt != SETTLE_MAX) settle_cnt = settle_cnt + 1'b1;
      end
      FUNC_POLL: begin
        if (!waiting) begin
          sel_lines  = scan_pos;
          settle_cnt = '0;
          waiting    = 1'b1;
        end else if (settle_cnt >= cur_settle) begin
          pos  = int'(scan_pos);
          slot = cur_rev ? CH - 1 - pos : pos;
          raw_mem[slot]    = smp;
          smooth_mem[slot] = pass_done ? ema_step(smooth_mem[slot], smp, cur_shift) : smp;
          r.sample_stored  = 1'b1;
          r.slot_written   = SEL_W'(slot);
          r.raw_value      = raw_mem[slot];
          r.smooth_value   = smooth_mem[slot];
          if (pos + 1 >= CH) begin
            scan_pos  = '0;
            pass_done = 1'b1;
          end else begin
            scan_pos = SEL_W'(pos + 1);
          end
          waiting = 1'b0;
        end
      end
      FUNC_READ: begin
        if (int'(rs) < CH) begin
          r.raw_value    = raw_mem[int'(rs)];
          r.smooth_value = smooth_mem[int'(rs)];
        end
      end
      default: ;
    endcase
    r.mux_select = sel_lines;
    r.scan_valid = pass_done;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got_v, exp_v);
  endtask

  task automatic check_result(input result_t got, input result_t exp_r);
    if (got.mux_select !== exp_r.mux_select)
      report_mismatch("mux_select", got.mux_select, exp_r.mux_select);
    if (got.sample_stored !== exp_r.sample_stored)
      report_mismatch("sample_stored", got.sample_stored, exp_r.sample_stored);
    if (got.slot_written !== exp_r.slot_written)
      report_mismatch("slot_written", got.slot_written, exp_r.slot_written);
    if (got.raw_value !== exp_r.raw_value)
      report_mismatch("raw_value", got.raw_value, exp_r.raw_value);
    if (got.smooth_value !== exp_r.smooth_value)
      report_mismatch("smooth_value", got.smooth_value, exp_r.smooth_value);
    if (got.scan_valid !== exp_r.scan_valid)
      report_mismatch("scan_valid", got.scan_valid, exp_r.scan_valid);
  endtask

  // Monitor: config tracking, result check, prediction, watchdog
  always @(posedge clk) begin
    logic    in_acc;
    logic    out_acc;
    result_t got;
    result_t pred;
    if (!rst_n) begin
      scan_reset();
      expected_q.delete();
      idle_run = 0;
    end else begin
      in_acc  = in_bus.valid && in_bus.ready;
      out_acc = out_bus.valid && out_bus.ready;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FILTER_SHIFT:  cur_shift  = cfg_data[SHIFT_W-1:0];
          CFG_SETTLE_TICKS:  cur_settle = cfg_data[SETTLE_W-1:0];
          CFG_REVERSE_ORDER: cur_rev    = cfg_data[0];
          default: ;
        endcase
      end
      if (out_acc) begin
        got.mux_select    = out_bus.mux_select;
        got.sample_stored = out_bus.sample_stored;
        got.slot_written  = out_bus.slot_written;
        got.raw_value     = out_bus.raw_value;
        got.smooth_value  = out_bus.smooth_value;
        got.scan_valid    = out_bus.scan_valid;
        if (expected_q.size() == 0) report_mismatch("unexpected transaction", 0, 0);
        else check_result(got, expected_q.pop_front());
      end
      if (in_acc) begin
        pred = scan_model(in_bus.func, in_bus.adc_sample, in_bus.read_slot);
        expected_q.push_back(drv_typed ? drv_res : pred);
      end
      if (in_acc || out_acc) idle_run = 0;
      else idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls plus long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [FUNC_W-1:0]   fn,
                           input logic [SAMPLE_W-1:0] smp,
                           input logic [RSLOT_W-1:0]  rs,
                           input logic                typed,
                           input result_t             res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= fn;
    in_bus.adc_sample <= smp;
    in_bus.read_slot  <= rs;
    drv_typed         <= typed;
    drv_res           <= res;
    @(posedge clk);
    while (!(in_bus.valid && in_bus.ready)) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_rand(input logic [FUNC_W-1:0] fn);
    send_item(fn, SAMPLE_W'($urandom), RSLOT_W'($urandom), 1'b0, '0);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One channel visit: select, settle ticks (maybe an early poll), sample.
  task automatic scan_burst();
    int waits;
    int early;
    if ($urandom_range(99) < 15) send_rand(FUNC_W'($urandom_range(3)));
    send_rand(FUNC_POLL);
    waits = int'(cur_settle) + $urandom_range(3);
    early = (cur_settle > 0 && $urandom_range(3) == 0) ? $urandom_range(cur_settle - 1) : -1;
    for (int k = 0; k < waits; k++) begin
      if (k == early) send_rand(FUNC_POLL);
      if ($urandom_range(99) < 10) send_rand(FUNC_READ);
      send_rand(FUNC_TICK);
    end
    send_item(FUNC_POLL, pick_sample(), RSLOT_W'($urandom), 1'b0, '0);
    if ($urandom_range(99) < 35) send_rand(FUNC_READ);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [SHIFT_W-1:0]  shift,
                            input logic [SETTLE_W-1:0] settle,
                            input logic                rev);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_FILTER_SHIFT;
    cfg_data <= CFG_DATA_W'(shift);
    @(negedge clk);
    cfg_addr <= CFG_SETTLE_TICKS;
    cfg_data <= CFG_DATA_W'(settle);
    @(negedge clk);
    cfg_addr <= CFG_REVERSE_ORDER;
    cfg_data <= CFG_DATA_W'(rev);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int start;
    in_bus.valid      = 1'b0;
    in_bus.func       = FUNC_TICK;
    in_bus.adc_sample = '0;
    in_bus.read_slot  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(dir_rows[i].fn, dir_rows[i].smp, dir_rows[i].rs,
                dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_regs(phases[p].shift, phases[p].settle, phases[p].rev);
      send_idle_pct  = phases[p].idle_pct;
      recv_stall_pct = phases[p].stall_pct;
      if (phases[p].press) begin
        @(posedge clk);
        hold_req = HOLD_CYCLES;
        @(negedge clk);
      end
      start = items_sent;
      while (items_sent - start < phases[p].items) scan_burst();
    end

    recv_stall_pct = 0;
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/mss_pkg.sv
hdl/mss_in_if.sv
hdl/mss_out_if.sv
hdl/mux_sensor_scan_smoother.sv
verif/tb_mux_sensor_scan_smoother.sv
